>>> hw/rtl/frxc_pkg.sv
// Shared types and constants for the frame receiver with XOR check byte.
package frxc_pkg;

  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 32;
  localparam int PLEN_W  = 6;
  localparam int PIDX_W  = 6;
  localparam int TAKEN_W = 7;

  localparam int MAX_FRAME_BYTES_DEF = 64;

  // Length, command and check byte around the payload, plus the start byte.
  localparam int FRAME_OVERHEAD = 4;

  localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h02;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_OK   = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef struct packed {
    status_t             frame_status;
    logic [BYTE_W-1:0]   command;
    logic [PLEN_W-1:0]   payload_length;
    logic                payload_valid;
    logic [BYTE_W-1:0]   payload_byte;
    logic [PIDX_W-1:0]   payload_index;
    logic [CNT_W-1:0]    dropped_count;
    logic [CNT_W-1:0]    broken_count;
    logic [CNT_W-1:0]    good_count;
    logic [CNT_W-1:0]    checksum_error_count;
  } frxc_result_t;

endpackage

>>> hw/rtl/frxc_if.sv
// Channel interfaces: received bytes, per-byte results and the start byte write.
interface frxc_byte_if;
  import frxc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface frxc_result_if;
  import frxc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        frame_status;
  logic [BYTE_W-1:0] command;
  logic [PLEN_W-1:0] payload_length;
  logic              payload_valid;
  logic [BYTE_W-1:0] payload_byte;
  logic [PIDX_W-1:0] payload_index;
  logic [CNT_W-1:0]  dropped_count;
  logic [CNT_W-1:0]  broken_count;
  logic [CNT_W-1:0]  good_count;
  logic [CNT_W-1:0]  checksum_error_count;

  modport source (
    output valid, frame_status, command, payload_length, payload_valid,
           payload_byte, payload_index, dropped_count, broken_count,
           good_count, checksum_error_count,
    input  ready
  );
  modport sink (
    input  valid, frame_status, command, payload_length, payload_valid,
           payload_byte, payload_index, dropped_count, broken_count,
           good_count, checksum_error_count,
    output ready
  );
endinterface

interface frxc_cfg_if;
  import frxc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] start_byte;

  modport source (output valid, output start_byte, input ready);
  modport sink (input valid, input start_byte, output ready);
endinterface

>>> hw/rtl/frame_receiver_xor_checksum_unit.sv
// An accepted byte passes the input register, then the result register, on its way to its result beat.
// Throughput: one byte per cycle; the parse step and running XOR fit between the two registers.
// Both registers stall together only when the result beat is not taken downstream.
// Reset (rst, synchronous): parser idle, held fields and counters zero, start byte 0x02.
// The start byte register may be written at any cycle; write it while no frame is in flight.
module frame_receiver_xor_checksum_unit import frxc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  frxc_byte_if.sink     rx,
  frxc_result_if.source result,
  frxc_cfg_if.sink      cfg
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              out_valid;
  frxc_result_t      out_res;
  frxc_result_t      step_res;
  logic [BYTE_W-1:0] start_byte;
  logic              advance;

  assign advance  = in_valid && (!out_valid || result.ready);
  assign rx.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
    end else if (cfg.valid) begin
      start_byte <= cfg.start_byte;
    end
  end

  // Input register: load a new beat when empty or whenever the held one moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  frxc_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .rx_byte    (in_byte),
    .start_byte (start_byte),
    .res        (step_res)
  );

  // Result register: hold until taken, refill in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign result.valid                = out_valid;
  assign result.frame_status         = out_res.frame_status;
  assign result.command              = out_res.command;
  assign result.payload_length       = out_res.payload_length;
  assign result.payload_valid        = out_res.payload_valid;
  assign result.payload_byte         = out_res.payload_byte;
  assign result.payload_index        = out_res.payload_index;
  assign result.dropped_count        = out_res.dropped_count;
  assign result.broken_count         = out_res.broken_count;
  assign result.good_count           = out_res.good_count;
  assign result.checksum_error_count = out_res.checksum_error_count;

endmodule

>>> hw/rtl/frxc_parser.sv
// Frame parse state, running XOR and event counters; one byte per step.
module frxc_parser import frxc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic [BYTE_W-1:0] start_byte,
  output frxc_result_t      res
);

  localparam int MAX_PAYLOAD = MAX_FRAME_BYTES - FRAME_OVERHEAD;
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
  localparam logic [BYTE_W:0] LEN_LIMIT = (BYTE_W+1)'(MAX_PAYLOAD);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_CMD     = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

  phase_t             phase, phase_next;
  logic [LEN_W-1:0]   announced_length, announced_length_next;
  logic [TAKEN_W-1:0] bytes_taken, bytes_taken_next;
  logic [BYTE_W-1:0]  running_xor, running_xor_next;
  logic [BYTE_W-1:0]  held_command, held_command_next;
  logic [CNT_W-1:0]   dropped_total, dropped_total_next;
  logic [CNT_W-1:0]   broken_total, broken_total_next;
  logic [CNT_W-1:0]   good_total, good_total_next;
  logic [CNT_W-1:0]   bad_check_total, bad_check_total_next;
  status_t            status;
  logic               pvalid;
  logic [PIDX_W-1:0]  pindex;

  always_comb begin
    phase_next            = phase;
    announced_length_next = announced_length;
    bytes_taken_next      = bytes_taken;
    running_xor_next      = running_xor;
    held_command_next     = held_command;
    dropped_total_next    = dropped_total;
    broken_total_next     = broken_total;
    good_total_next       = good_total;
    bad_check_total_next  = bad_check_total;
    status                = ST_NONE;
    pvalid                = 1'b0;
    pindex                = '0;

    case (phase)
      PH_IDLE: begin
        if (rx_byte == start_byte) begin
          phase_next       = PH_LEN;
          running_xor_next = '0;
          bytes_taken_next = '0;
        end else begin
          dropped_total_next = dropped_total + 1'b1;
        end
      end
      PH_LEN: begin
        // Oversize length abandons the frame; held length stays.
        if ({1'b0, rx_byte} > LEN_LIMIT) begin
          phase_next        = PH_IDLE;
          broken_total_next = broken_total + 1'b1;
        end else begin
          announced_length_next = LEN_W'(rx_byte);
          running_xor_next      = rx_byte;
          phase_next            = PH_CMD;
        end
      end
      PH_CMD: begin
        held_command_next = rx_byte;
        running_xor_next  = running_xor ^ rx_byte;
        phase_next = (announced_length == '0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        pvalid           = 1'b1;
        pindex           = bytes_taken[PIDX_W-1:0];
        running_xor_next = running_xor ^ rx_byte;
        bytes_taken_next = bytes_taken + 1'b1;
        if (8'(bytes_taken_next) >= 8'(announced_length)) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (running_xor == rx_byte) begin
          good_total_next = good_total + 1'b1;
          status          = ST_OK;
        end else begin
          bad_check_total_next = bad_check_total + 1'b1;
          status               = ST_BAD;
        end
        phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    res.frame_status         = status;
    res.command              = held_command_next;
    res.payload_length       = PLEN_W'(announced_length_next);
    res.payload_valid        = pvalid;
    res.payload_byte         = pvalid ? rx_byte : '0;
    res.payload_index        = pindex;
    res.dropped_count        = dropped_total_next;
    res.broken_count         = broken_total_next;
    res.good_count           = good_total_next;
    res.checksum_error_count = bad_check_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      announced_length <= '0;
      bytes_taken      <= '0;
      running_xor      <= '0;
      held_command     <= '0;
      dropped_total    <= '0;
      broken_total     <= '0;
      good_total       <= '0;
      bad_check_total  <= '0;
    end else if (step) begin
      phase            <= phase_next;
      announced_length <= announced_length_next;
      bytes_taken      <= bytes_taken_next;
      running_xor      <= running_xor_next;
      held_command     <= held_command_next;
      dropped_total    <= dropped_total_next;
      broken_total     <= broken_total_next;
      good_total       <= good_total_next;
      bad_check_total  <= bad_check_total_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_check_ends_frame: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_CHECK |=> phase == PH_IDLE)
    else $error("check byte did not return parser to idle");

  a_one_verdict: assert property (@(posedge clk) disable iff (rst)
    !(good_total != $past(good_total) && bad_check_total != $past(bad_check_total)))
    else $error("frame counted both good and bad");

  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(running_xor) && $stable(bytes_taken))
    else $error("parse state moved without a beat");

  a_payload_no_status: assert property (@(posedge clk) disable iff (rst)
    res.payload_valid |-> res.frame_status == ST_NONE)
    else $error("payload beat carries a frame verdict");
`endif

endmodule

>>> verif/frxc_checker.sv
// Checker for the frame receiver: predicts every result beat and compares it.
module frxc_checker import frxc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  frxc_byte_if        rx,
  frxc_result_if      result,
  frxc_cfg_if         cfg,
  output int          fail_count,
  output int          pending,
  output int          beats_checked,
  output logic [31:0] good_frames,
  output logic [31:0] bad_frames,
  output logic [31:0] oversize_frames,
  output logic [31:0] dropped_bytes
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_CMD     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } parse_phase_t;

  parse_phase_t         phase;
  logic [BYTE_W-1:0]    start_value;
  logic [PLEN_W-1:0]    ann_len;
  logic [TAKEN_W-1:0]   taken;
  logic [BYTE_W-1:0]    xor_acc;
  logic [BYTE_W-1:0]    cmd_hold;
  logic [CNT_W-1:0]     dropped_tot;
  logic [CNT_W-1:0]     broken_tot;
  logic [CNT_W-1:0]     good_tot;
  logic [CNT_W-1:0]     bad_tot;
  frxc_result_t         byte_results_due[$];
  int                   mismatches;

  assign fail_count      = mismatches;
  assign good_frames     = good_tot;
  assign bad_frames      = bad_tot;
  assign oversize_frames = broken_tot;
  assign dropped_bytes   = dropped_tot;

  task automatic report_fail(input string msg);
    if (mismatches < 40) $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_fail($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Advance the parser by one received byte and return the beat it yields.
  function automatic frxc_result_t parse_byte(input logic [BYTE_W-1:0] b);
    frxc_result_t r;
    r = '0;
    r.frame_status = ST_NONE;
    case (phase)
      PH_IDLE: begin
        if (b == start_value) begin
          phase   = PH_LEN;
          xor_acc = '0;
          taken   = '0;
        end else begin
          dropped_tot = dropped_tot + 1;
        end
      end
      PH_LEN: begin
        if (int'(b) > MAX_FRAME_BYTES - FRAME_OVERHEAD) begin
          phase      = PH_IDLE;
          broken_tot = broken_tot + 1;
        end else begin
          ann_len = b[PLEN_W-1:0];
          xor_acc = b;
          phase   = PH_CMD;
        end
      end
      PH_CMD: begin
        cmd_hold = b;
        xor_acc  = xor_acc ^ b;
        phase    = (ann_len == '0) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = taken[PIDX_W-1:0];
        xor_acc = xor_acc ^ b;
        taken   = taken + 1'b1;
        if (taken >= {1'b0, ann_len}) phase = PH_CHECK;
      end
      PH_CHECK: begin
        if (xor_acc == b) begin
          good_tot = good_tot + 1;
          r.frame_status = ST_OK;
        end else begin
          bad_tot = bad_tot + 1;
          r.frame_status = ST_BAD;
        end
        phase = PH_IDLE;
      end
      default: phase = PH_IDLE;
    endcase
    r.command              = cmd_hold;
    r.payload_length       = ann_len;
    r.dropped_count        = dropped_tot;
    r.broken_count         = broken_tot;
    r.good_count           = good_tot;
    r.checksum_error_count = bad_tot;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    frxc_result_t want;
    if (rst) begin
      phase         = PH_IDLE;
      start_value   = START_BYTE_RESET;
      ann_len       = '0;
      taken         = '0;
      xor_acc       = '0;
      cmd_hold      = '0;
      dropped_tot   = '0;
      broken_tot    = '0;
      good_tot      = '0;
      bad_tot       = '0;
      mismatches    = 0;
      beats_checked = 0;
      byte_results_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) start_value = cfg.start_byte;
      if (rx.valid && rx.ready) byte_results_due.push_back(parse_byte(rx.rx_byte));
      if (result.valid && result.ready) begin
        beats_checked++;
        if (byte_results_due.size() == 0) begin
          report_fail("result beat with no byte outstanding");
        end else begin
          want = byte_results_due.pop_front();
          check_field("frame_status", 32'(result.frame_status), 32'(want.frame_status));
          check_field("command", 32'(result.command), 32'(want.command));
          check_field("payload_length", 32'(result.payload_length),
                      32'(want.payload_length));
          check_field("payload_valid", 32'(result.payload_valid), 32'(want.payload_valid));
          check_field("payload_byte", 32'(result.payload_byte), 32'(want.payload_byte));
          check_field("payload_index", 32'(result.payload_index), 32'(want.payload_index));
          check_field("dropped_count", result.dropped_count, want.dropped_count);
          check_field("broken_count", result.broken_count, want.broken_count);
          check_field("good_count", result.good_count, want.good_count);
          check_field("checksum_error_count", result.checksum_error_count,
                      want.checksum_error_count);
        end
      end
    end
    pending = byte_results_due.size();
  end

endmodule

>>> verif/tb_top.sv
// Top of the frame receiver testbench: clock, reset, byte stimulus and verdict.
module tb_top;
  import frxc_pkg::*;

  localparam int MAX_FRAME    = MAX_FRAME_BYTES_DEF;
  localparam int MAX_PAYLOAD  = MAX_FRAME - FRAME_OVERHEAD;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 320;
  localparam int LIMIT_CYCLES = 1000000;

  logic clk = 1'b0;
  logic rst;

  frxc_byte_if   rx_if ();
  frxc_result_if res_if ();
  frxc_cfg_if    cfg_if ();

  int          fail_count;
  int          pending;
  int          beats_checked;
  logic [31:0] good_frames;
  logic [31:0] bad_frames;
  logic [31:0] oversize_frames;
  logic [31:0] dropped_bytes;

  int          items_sent = 0;
  int          settings_used = 1;
  bit          calm = 1'b0;
  logic [7:0]  sof = START_BYTE_RESET;

  frame_receiver_xor_checksum_unit #(.MAX_FRAME_BYTES(MAX_FRAME)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  frxc_checker #(.MAX_FRAME_BYTES(MAX_FRAME)) i_checker (
    .clk             (clk),
    .rst             (rst),
    .rx              (rx_if),
    .result          (res_if),
    .cfg             (cfg_if),
    .fail_count      (fail_count),
    .pending         (pending),
    .beats_checked   (beats_checked),
    .good_frames     (good_frames),
    .bad_frames      (bad_frames),
    .oversize_frames (oversize_frames),
    .dropped_bytes   (dropped_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_cycles();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap_cycles()) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // Send a whole frame; an oversize length ends it after the length byte.
  task automatic send_frame(input int len, input bit good_check);
    logic [7:0] acc;
    logic [7:0] b;
    push_byte(sof);
    push_byte(8'(len));
    if (len <= MAX_PAYLOAD) begin
      acc = 8'(len);
      b = 8'($urandom);
      acc ^= b;
      push_byte(b);
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom);
        acc ^= b;
        push_byte(b);
      end
      push_byte(good_check ? acc : acc ^ 8'($urandom_range(1, 255)));
    end
  endtask

  task automatic random_traffic(input int n_bytes);
    int stop;
    int pick;
    int len;
    logic [7:0] b;
    stop = items_sent + n_bytes;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) begin
          do b = 8'($urandom); while (b == sof);
          push_byte(b);
        end
      end else if (pick < 14) begin
        send_frame($urandom_range(MAX_PAYLOAD + 1, 255), 1'b1);
      end else if (pick < 18) begin
        // Cut the frame short inside its payload and carry on regardless.
        len = $urandom_range(2, 12);
        push_byte(sof);
        push_byte(8'(len));
        push_byte(8'($urandom));
        repeat ($urandom_range(0, len - 1)) push_byte(8'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) len = $urandom_range(0, 6);
        else if (pick < 95) len = $urandom_range(7, 20);
        else len = $urandom_range(21, MAX_PAYLOAD);
        send_frame(len, $urandom_range(0, 9) < 8);
      end
    end
  endtask

  // Wait until every byte has its result, then write the start byte.
  task automatic set_start_byte(input logic [7:0] v);
    rx_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.start_byte <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    sof = v;
    settings_used++;
  endtask

  initial begin : result_sink
    int stretch;
    bit held_off;
    held_off = 1'b0;
    forever begin
      if (!held_off && items_sent >= HOLD_AT) begin
        held_off = 1'b1;
        res_if.ready <= 1'b0;
        stretch = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 9) < 3) begin
        res_if.ready <= 1'b0;
        stretch = gap_cycles();
      end else begin
        res_if.ready <= 1'b1;
        stretch = $urandom_range(1, 12);
      end
      repeat (stretch) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [7:0] setting;
    rst               <= 1'b1;
    rx_if.valid       <= 1'b0;
    rx_if.rx_byte     <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.start_byte <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Bytes outside a frame get dropped.
    push_byte(8'h00);
    push_byte(8'hFF);
    // Zero-length frame goes straight from command to check.
    push_byte(sof); push_byte(8'h00); push_byte(8'hFF); push_byte(8'hFF);
    // Length just over the limit, then the largest byte value as length; both are oversize.
    push_byte(sof); push_byte(8'(MAX_PAYLOAD + 1));
    push_byte(sof); push_byte(8'hFF);
    // Start byte inside the payload is data; check byte wrong on purpose.
    push_byte(sof); push_byte(8'h02); push_byte(8'h00);
    push_byte(sof); push_byte(8'hFF); push_byte(8'h00);
    // One payload byte with a correct check.
    push_byte(sof); push_byte(8'h01); push_byte(8'hA5); push_byte(8'h5A);
    push_byte(8'hFE);

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: setting = 8'h00;
        2: setting = 8'hFF;
        3: setting = 8'($urandom);
        4: setting = START_BYTE_RESET;
        default: setting = sof;
      endcase
      if (p > 0) set_start_byte(setting);
      calm = (p == 3);
      send_frame(MAX_PAYLOAD, 1'b1);
      random_traffic(PHASE_BYTES);
    end

    rx_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes under %0d start-byte settings, with random stalls on both sides",
             items_sent, settings_used);
    $display("and a %0d-cycle result hold-off; %0d beats checked:",
             HOLD_CYCLES, beats_checked);
    $display("  %0d ok, %0d bad check, %0d oversize, %0d dropped",
             good_frames, bad_frames, oversize_frames, dropped_bytes);
    if (fail_count == 0) begin
      $display("PASS frame_receiver_xor_checksum_unit");
    end else begin
      $display("FAIL frame_receiver_xor_checksum_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 10);
    $display("Run did not finish within %0d cycles", LIMIT_CYCLES);
    $display("FAIL frame_receiver_xor_checksum_unit");
    $finish;
  end

endmodule
